/* sv/csc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, state and command codes, and per-state tables for the
// cannon sequence controller.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int ModeW = 4;
    localparam int CmdW  = 3;

    typedef logic [ModeW-1:0] t_mode;
    typedef logic [CmdW-1:0]  t_cmd;
    typedef logic [15:0]      t_mask;

    localparam t_mode ST_HOME_STAT  = 4'd0;
    localparam t_mode ST_READY      = 4'd1;
    localparam t_mode ST_HOME_MOV   = 4'd2;
    localparam t_mode ST_ON_MARK    = 4'd3;
    localparam t_mode ST_FIRE_READY = 4'd4;
    localparam t_mode ST_FORGOTTEN  = 4'd5;
    localparam t_mode ST_FIRED      = 4'd6;
    localparam t_mode ST_GET_HOME   = 4'd7;
    localparam t_mode ST_FINDING    = 4'd8;

    localparam t_cmd CMD_HOME_SW   = 3'd0;
    localparam t_cmd CMD_MARK_EDGE = 3'd1;
    localparam t_cmd CMD_BALL_IN   = 3'd2;
    localparam t_cmd CMD_KICK_OK   = 3'd3;
    localparam t_cmd CMD_RESET     = 3'd4;
    localparam t_cmd CMD_FIRE      = 3'd5;
    localparam t_cmd CMD_START     = 3'd6;

    typedef struct packed {
        t_cmd cmd;
        logic mark_level;
        logic gun_loaded;
    } t_event;

    typedef struct packed {
        t_mode mode;
        logic  eject;
        logic  err;
    } t_step_res;

    // legal destinations from each state
    function automatic t_mask allowed_to(input t_mode from);
        t_mask m;
        m = '0;
        case (from)
            ST_HOME_STAT:  m[ST_READY] = 1'b1;
            ST_READY:      m[ST_HOME_MOV] = 1'b1;
            ST_HOME_MOV:   m[ST_ON_MARK] = 1'b1;
            ST_ON_MARK:    m[ST_FIRE_READY] = 1'b1;
            ST_FIRE_READY: begin
                m[ST_FORGOTTEN] = 1'b1;
                m[ST_FIRED]     = 1'b1;
            end
            ST_FORGOTTEN:  m[ST_FIRED] = 1'b1;
            ST_FIRED:      m[ST_HOME_STAT] = 1'b1;
            ST_GET_HOME: begin
                m[ST_FINDING]   = 1'b1;
                m[ST_HOME_MOV]  = 1'b1;
                m[ST_HOME_STAT] = 1'b1;
            end
            ST_FINDING:    m[ST_GET_HOME] = 1'b1;
            default:       m = '0;
        endcase
        return m;
    endfunction

    function automatic logic move_ok(input t_mode from, input t_mode to);
        t_mask m;
        m = allowed_to(from);
        return (from == to) || (to == ST_GET_HOME) || m[to];
    endfunction

    function automatic logic entry_motor(input t_mode s);
        return !((s == ST_HOME_STAT) || (s == ST_READY) || (s == ST_GET_HOME));
    endfunction

    function automatic logic entry_fire(input t_mode s);
        return (s == ST_FIRE_READY) || (s == ST_FORGOTTEN);
    endfunction

endpackage

/* sv/csc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_step
// Event decode and transition check: next state, eject and error flags
// for one event against the current state.
// ----------------------------------------------------------------------------
module csc_step
    import csc_pkg::*;
(
    input  t_event    i_evt,
    input  t_mode     i_mode,
    output t_step_res o_res
);

    t_mode n_mode;
    logic  n_eject;
    logic  n_err;

    always_comb begin
        n_mode  = i_mode;
        n_eject = 1'b0;
        n_err   = 1'b0;
        case (i_evt.cmd)
            CMD_HOME_SW: begin
                if (i_mode == ST_FIRED) begin
                    n_mode = ST_HOME_STAT;
                end else if (i_mode == ST_FINDING) begin
                    // passes through get home, both moves legal from there
                    n_mode = i_evt.gun_loaded ? ST_HOME_MOV : ST_HOME_STAT;
                end else begin
                    n_err = 1'b1;
                end
            end
            CMD_MARK_EDGE: begin
                if (i_evt.mark_level) begin
                    if (i_mode == ST_HOME_MOV) n_mode = ST_ON_MARK;
                    else n_err = 1'b1;
                end else begin
                    if (i_mode == ST_ON_MARK) begin
                        n_mode = ST_FIRE_READY;
                    end else if (i_mode == ST_FIRE_READY) begin
                        n_mode  = ST_FORGOTTEN;
                        n_eject = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end
            CMD_BALL_IN: begin
                if (i_mode == ST_HOME_STAT) n_mode = ST_READY;
                else n_err = 1'b1;
            end
            CMD_KICK_OK: begin
                if (i_mode == ST_FIRE_READY || i_mode == ST_FORGOTTEN) n_mode = ST_FIRED;
                else n_err = 1'b1;
            end
            CMD_RESET: begin
                n_mode = ST_GET_HOME;
            end
            CMD_FIRE: begin
                n_eject = entry_fire(i_mode);
            end
            CMD_START: begin
                if (move_ok(i_mode, ST_HOME_MOV)) n_mode = ST_HOME_MOV;
                else n_err = 1'b1;
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    assign o_res = '{mode: n_mode, eject: n_eject, err: n_err};

endmodule

/* sv/cannon_sequence_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cannon_sequence_controller
// Nine-state ball cannon sequencer, one event in, one status result out.
// ----------------------------------------------------------------------------
// Each event is taken into an input register, checked against the current
// state by the transition logic, and its result (state, motor, fire enable,
// eject and error flags) lands in an output register. One event is accepted
// per clock while the output is not stalled; the state register updates as
// the event moves into the output register, so the next event sees it at
// once. Output valid rises as the result enters the output register; a
// stalled output holds the input side.
module cannon_sequence_controller
    import csc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_command,
    input  logic       i_mark_level,
    input  logic       i_gun_loaded,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_cannon_state,
    output logic       o_motor_on,
    output logic       o_fire_enabled,
    output logic       o_eject_request,
    output logic       o_event_error
);

    logic      r_in_vld;
    t_event    r_evt;
    t_mode     r_mode;
    logic      r_out_vld;
    t_step_res r_res;
    t_step_res n_res;
    logic      advance;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    csc_step u_step (
        .i_evt  (r_evt),
        .i_mode (r_mode),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode    <= ST_HOME_STAT;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_mode    <= n_res.mode;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_evt <= '{cmd: i_command, mark_level: i_mark_level, gun_loaded: i_gun_loaded};
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_cannon_state  = r_res.mode;
    assign o_motor_on      = entry_motor(r_res.mode);
    assign o_fire_enabled  = entry_fire(r_res.mode);
    assign o_eject_request = r_res.eject;
    assign o_event_error   = r_res.err;

endmodule

/* sv/csc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks on the controller result stream, bound to the top level.
// ----------------------------------------------------------------------------
module csc_checker
    import csc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_ready,
    input logic       i_out_valid,
    input logic [3:0] i_cannon_state,
    input logic       i_motor_on,
    input logic       i_fire_enabled,
    input logic       i_eject_request
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cannon_state))
        else $error("result changed while stalled");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cannon_state <= ST_FINDING)
        else $error("state out of range");

    a_fire_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fire_enabled |->
            (i_cannon_state == ST_FIRE_READY || i_cannon_state == ST_FORGOTTEN))
        else $error("fire enabled outside fire ready or forgotten");

    a_eject_permit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_eject_request |-> i_fire_enabled)
        else $error("eject without fire permit");

    a_motor_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_cannon_state == ST_HOME_STAT || i_cannon_state == ST_READY
            || i_cannon_state == ST_GET_HOME) |-> !i_motor_on)
        else $error("motor on in a stopped state");

endmodule

bind cannon_sequence_controller csc_checker u_csc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_ready     (i_out_ready),
    .i_out_valid     (o_out_valid),
    .i_cannon_state  (o_cannon_state),
    .i_motor_on      (o_motor_on),
    .i_fire_enabled  (o_fire_enabled),
    .i_eject_request (o_eject_request)
);

/* test/tb_cannon_sequence_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cannon_sequence_controller
// Self-checking bench for the ball cannon sequencer.
// ----------------------------------------------------------------------------
// Events are pushed through the valid/ready input with random gaps while the
// output side stalls at random. A scoreboard keeps its own copy of the cannon
// state, works out the status for every accepted event, and compares each
// returned status against the oldest one still pending. Stimulus starts with
// a short directed walk through every command and the awkward corners of the
// state machine, then mostly well-formed firing sequences mixed with noise,
// under four idle profiles.
// ----------------------------------------------------------------------------
module tb_cannon_sequence_controller;
    import csc_pkg::*;

    localparam t_cmd CMD_UNUSED = 3'd7;
    localparam int   STALL_LIMIT = 2000;
    localparam int   ITEMS_PER_PHASE = 100;

    typedef struct packed {
        t_mode mode;
        logic  fire_permit;
        logic  motor_drive;
    } t_cannon_regs;

    typedef struct packed {
        t_mode state;
        logic  motor;
        logic  fire_en;
        logic  eject;
        logic  err;
    } t_cannon_status;

    class status_book;
        t_cannon_regs   regs;
        t_cannon_status pending_status[$];
        int             mismatches;

        function new();
            regs.mode        = ST_HOME_STAT;
            regs.fire_permit = 1'b0;
            regs.motor_drive = 1'b0;
            mismatches       = 0;
        endfunction

        static function logic table_allows(t_mode from, t_mode to);
            case (from)
                ST_HOME_STAT:  return to == ST_READY;
                ST_READY:      return to == ST_HOME_MOV;
                ST_HOME_MOV:   return to == ST_ON_MARK;
                ST_ON_MARK:    return to == ST_FIRE_READY;
                ST_FIRE_READY: return (to == ST_FORGOTTEN) || (to == ST_FIRED);
                ST_FORGOTTEN:  return to == ST_FIRED;
                ST_FIRED:      return to == ST_HOME_STAT;
                ST_GET_HOME: begin
                    return (to == ST_FINDING) || (to == ST_HOME_MOV) || (to == ST_HOME_STAT);
                end
                ST_FINDING:    return to == ST_GET_HOME;
                default:       return 1'b0;
            endcase
        endfunction

        // returns 1 when the move is refused
        static function logic try_move(inout t_cannon_regs r, inout logic ej, input t_mode to);
            if (!((r.mode == to) || (to == ST_GET_HOME) || table_allows(r.mode, to))) begin
                return 1'b1;
            end
            r.motor_drive = !((to == ST_HOME_STAT) || (to == ST_READY) || (to == ST_GET_HOME));
            r.fire_permit = (to == ST_FIRE_READY) || (to == ST_FORGOTTEN);
            if (to == ST_FORGOTTEN) begin
                ej = 1'b1;
            end
            r.mode = to;
            return 1'b0;
        endfunction

        static function t_cannon_status step(inout t_cannon_regs r, input t_cmd c,
                                             input logic lvl, input logic ld);
            t_cannon_status s;
            logic ej;
            logic err;
            ej  = 1'b0;
            err = 1'b0;
            case (c)
                CMD_HOME_SW: begin
                    if (r.mode == ST_FIRED) begin
                        err = try_move(r, ej, ST_HOME_STAT);
                    end else if (r.mode == ST_FINDING) begin
                        err = try_move(r, ej, ST_GET_HOME);
                        err |= try_move(r, ej, ld ? ST_HOME_MOV : ST_HOME_STAT);
                    end else begin
                        err = 1'b1;
                    end
                end
                CMD_MARK_EDGE: begin
                    if (lvl) begin
                        if (r.mode == ST_HOME_MOV) err = try_move(r, ej, ST_ON_MARK);
                        else err = 1'b1;
                    end else if (r.mode == ST_ON_MARK) begin
                        err = try_move(r, ej, ST_FIRE_READY);
                    end else if (r.mode == ST_FIRE_READY) begin
                        err = try_move(r, ej, ST_FORGOTTEN);
                    end else begin
                        err = 1'b1;
                    end
                end
                CMD_BALL_IN: begin
                    if (r.mode == ST_HOME_STAT) err = try_move(r, ej, ST_READY);
                    else err = 1'b1;
                end
                CMD_KICK_OK: begin
                    if ((r.mode == ST_FIRE_READY) || (r.mode == ST_FORGOTTEN)) begin
                        err = try_move(r, ej, ST_FIRED);
                    end else begin
                        err = 1'b1;
                    end
                end
                CMD_RESET: begin
                    r.fire_permit = 1'b0;
                    err = try_move(r, ej, ST_GET_HOME);
                end
                CMD_FIRE: begin
                    ej = r.fire_permit;
                end
                CMD_START: begin
                    err = try_move(r, ej, ST_HOME_MOV);
                end
                default: begin
                    err = 1'b1;
                end
            endcase
            s.state   = r.mode;
            s.motor   = r.motor_drive;
            s.fire_en = r.fire_permit;
            s.eject   = ej;
            s.err     = err;
            return s;
        endfunction

        function void note_event(t_cmd c, logic lvl, logic ld);
            pending_status.push_back(step(regs, c, lvl, ld));
        endfunction

        function void check_status(t_cannon_status got);
            t_cannon_status want;
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected status transfer: state=%0d motor=%b fire=%b eject=%b err=%b",
                             got.state, got.motor, got.fire_en, got.eject, got.err);
                end
                return;
            end
            want = pending_status.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("status mismatch: exp state=%0d motor=%b fire=%b eject=%b err=%b",
                             want.state, want.motor, want.fire_en, want.eject, want.err);
                    $display("                 got state=%0d motor=%b fire=%b eject=%b err=%b",
                             got.state, got.motor, got.fire_en, got.eject, got.err);
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [2:0] cmd = '0;
    logic       mark_level = 1'b0;
    logic       gun_loaded = 1'b0;
    logic       out_ready = 1'b0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic [3:0] o_cannon_state;
    logic       o_motor_on;
    logic       o_fire_enabled;
    logic       o_eject_request;
    logic       o_event_error;

    status_book   book;
    t_cannon_regs gen_regs;
    int           sender_idle_pct = 0;
    int           sink_stall_pct = 0;
    int           quiet_cycles = 0;

    cannon_sequence_controller u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (cmd),
        .i_mark_level    (mark_level),
        .i_gun_loaded    (gun_loaded),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_cannon_state  (o_cannon_state),
        .o_motor_on      (o_motor_on),
        .o_fire_enabled  (o_fire_enabled),
        .o_eject_request (o_eject_request),
        .o_event_error   (o_event_error)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && o_in_ready) begin
            book.note_event(cmd, mark_level, gun_loaded);
        end
        if (rst_n && o_out_valid && out_ready) begin
            book.check_status('{o_cannon_state, o_motor_on, o_fire_enabled,
                                o_eject_request, o_event_error});
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // called at a clock edge; returns at the edge where the transfer happens
    task automatic push_event(t_cmd c, logic lvl, logic ld);
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        mark_level <= lvl;
        gun_loaded <= ld;
        void'(status_book::step(gen_regs, c, lvl, ld));
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
    endtask

    initial begin
        int     idle_plan[4][2];
        int     r;
        int     sel;
        t_cmd   c;
        logic   lvl;
        logic   ld;

        idle_plan = '{'{0, 0}, '{52, 0}, '{0, 52}, '{32, 32}};
        book = new();
        gen_regs = book.regs;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk from home stationary
        push_event(CMD_UNUSED, 1'b1, 1'b1);
        push_event(CMD_HOME_SW, 1'b0, 1'b1);
        push_event(CMD_MARK_EDGE, 1'b1, 1'b0);
        push_event(CMD_MARK_EDGE, 1'b0, 1'b1);
        push_event(CMD_KICK_OK, 1'b1, 1'b0);
        push_event(CMD_FIRE, 1'b0, 1'b0);
        push_event(CMD_START, 1'b1, 1'b1);
        push_event(CMD_BALL_IN, 1'b0, 1'b0);
        push_event(CMD_BALL_IN, 1'b1, 1'b1);
        push_event(CMD_START, 1'b0, 1'b0);
        push_event(CMD_START, 1'b1, 1'b0);
        push_event(CMD_MARK_EDGE, 1'b0, 1'b0);
        push_event(CMD_MARK_EDGE, 1'b1, 1'b1);
        push_event(CMD_MARK_EDGE, 1'b0, 1'b0);
        push_event(CMD_FIRE, 1'b1, 1'b1);
        push_event(CMD_MARK_EDGE, 1'b0, 1'b1);
        push_event(CMD_FIRE, 1'b0, 1'b0);
        push_event(CMD_KICK_OK, 1'b0, 1'b1);
        push_event(CMD_FIRE, 1'b1, 1'b0);
        push_event(CMD_HOME_SW, 1'b1, 1'b0);
        push_event(CMD_RESET, 1'b1, 1'b1);
        push_event(CMD_HOME_SW, 1'b0, 1'b0);
        push_event(CMD_START, 1'b0, 1'b1);
        push_event(CMD_MARK_EDGE, 1'b1, 1'b0);
        push_event(CMD_RESET, 1'b0, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = idle_plan[phase][0];
            sink_stall_pct  = idle_plan[phase][1];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r   = $urandom_range(99, 0);
                c   = t_cmd'($urandom_range(7, 0));
                lvl = 1'($urandom_range(1, 0));
                ld  = 1'($urandom_range(1, 0));
                if (r < 80) begin
                    // next step of a normal firing sequence
                    case (gen_regs.mode)
                        ST_HOME_STAT: c = CMD_BALL_IN;
                        ST_READY, ST_GET_HOME: c = CMD_START;
                        ST_HOME_MOV: begin
                            c   = CMD_MARK_EDGE;
                            lvl = 1'b1;
                        end
                        ST_ON_MARK: begin
                            c   = CMD_MARK_EDGE;
                            lvl = 1'b0;
                        end
                        ST_FIRE_READY: begin
                            sel = $urandom_range(2, 0);
                            c   = (sel == 0) ? CMD_FIRE : (sel == 1) ? CMD_KICK_OK : CMD_MARK_EDGE;
                            lvl = 1'b0;
                        end
                        ST_FORGOTTEN: c = $urandom_range(1, 0) ? CMD_KICK_OK : CMD_FIRE;
                        ST_FIRED: c = CMD_HOME_SW;
                        default: c = CMD_RESET;
                    endcase
                end else if (r < 86) begin
                    c = CMD_RESET;
                end
                push_event(c, lvl, ld);
            end
        end
        in_valid <= 1'b0;

        // let the last input transfer be noted before draining
        @(posedge clk);
        while (book.pending_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        if (book.mismatches == 0 && book.pending_status.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* cannon_sequence_controller.f */
sv/csc_pkg.sv
sv/csc_step.sv
sv/cannon_sequence_controller.sv
sv/csc_checker.sv
test/tb_cannon_sequence_controller.sv
